// ----- sv/fsc_pkg.sv -----
`default_nettype none

package fsc_pkg;

	// Number formats
	localparam int COORD_BITS  = 16;
	localparam int COEF_BITS   = 16;
	localparam int NORMAL_FRAC = 14;
	localparam int RAD_BITS    = COORD_BITS - 1;

	// Side planes held in registers and the number actually swept
	localparam int SIDE_PLANES = 4;
	localparam int PLANE_REGS  = 4;
	localparam int PLANES_USED = (SIDE_PLANES > PLANE_REGS) ? PLANE_REGS : SIDE_PLANES;
	localparam int PIDX_BITS   = $clog2(PLANE_REGS);

	// Datapath widths
	localparam int E_BITS     = ((COORD_BITS > COEF_BITS) ? COORD_BITS : COEF_BITS) + 1;
	localparam int PROD_BITS  = COEF_BITS + E_BITS;
	localparam int SUM_BITS   = PROD_BITS + 3;
	localparam int WIDE_BITS  = SUM_BITS + 1;
	localparam int SCALE_BITS = 16;
	localparam int RS_BITS    = RAD_BITS + SCALE_BITS + 2;
	localparam int DEPTH_BITS = COORD_BITS + COEF_BITS;
	localparam int PF_BITS    = 24;
	localparam int PIX_SHIFT  = 22;
	localparam int PIX_BITS   = 32;
	localparam int PIX_PROD   = DEPTH_BITS + PF_BITS;

	// Configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;
	localparam int VEC_BITS      = 3 * COEF_BITS;

	localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_TOP    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_RIGHT  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_BOTTOM = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_LEFT   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_EYE_POS      = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_EYE_DIR      = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH_SCALE  = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_FACTOR = 3'd7;

	localparam logic [VEC_BITS-1:0]   EYE_DIR_RESET     = 48'hC000_0000_0000;
	localparam logic [SCALE_BITS-1:0] DEPTH_SCALE_RESET = 16'd4096;

	// Request commands
	localparam logic [1:0] CMD_EVAL  = 2'd0;
	localparam logic [1:0] CMD_FOLD  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Sequencer steps: eye direction dot centre, dot eye offset, then the planes
	localparam int STEP_BITS = 3;
	localparam logic [STEP_BITS-1:0] STEP_DIR_C    = 3'd0;
	localparam logic [STEP_BITS-1:0] STEP_DIR_E    = 3'd1;
	localparam logic [STEP_BITS-1:0] STEP_PLANE0   = 3'd2;
	localparam logic [STEP_BITS-1:0] STEP_LAST_MUL = STEP_BITS'(1 + PLANES_USED);
	localparam logic [STEP_BITS-1:0] STEP_FIN      = STEP_BITS'(3 + PLANES_USED);

	localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	typedef struct packed {
		logic [PLANE_REGS-1:0][CFG_DATA_BITS-1:0] plane;
		logic [VEC_BITS-1:0]                      eye_pos;
		logic [VEC_BITS-1:0]                      eye_dir;
		logic [SCALE_BITS-1:0]                    depth_scale;
		logic [PF_BITS-1:0]                       pixel_factor;
	} cfg_t;

	typedef struct packed {
		logic                 load;
		logic                 mul_en;
		logic [STEP_BITS-1:0] step;
		logic                 fin;
	} dp_ctrl_t;

	// Drop the fraction towards minus infinity, then saturate to the coordinate range
	function automatic logic [COORD_BITS-1:0] to_coord(input logic signed [WIDE_BITS-1:0] v);
		logic [WIDE_BITS-NORMAL_FRAC-1:0]          s;
		logic [WIDE_BITS-NORMAL_FRAC-COORD_BITS:0] hi;
		logic [COORD_BITS-1:0]                     r;
		s  = v[WIDE_BITS-1:NORMAL_FRAC];
		hi = s[WIDE_BITS-NORMAL_FRAC-1:COORD_BITS-1];
		if (hi == '0 || hi == '1) begin
			r = s[COORD_BITS-1:0];
		end else if (s[WIDE_BITS-NORMAL_FRAC-1]) begin
			r = COORD_MIN;
		end else begin
			r = COORD_MAX;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/frustum_sphere_cull_core.sv -----
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  cmd, center_x/y/z, sphere_radius
// result    out        out_valid/out_stall  outside, min_distance, behind,
//                                           pixel_size, near_depth, far_depth
// config    in         cfg_we               cfg_index, cfg_wdata
//
// A new request is accepted only after the previous result has been loaded
// into the output register. The pace is set by the single three-multiplier
// dot-product unit, which serves one dot product per cycle.
// A finished result waits in the output register; a stalled result holds the
// sequencer at its last step. Reset clears control state and the depth range.
`default_nettype none

module frustum_sphere_cull_core (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [1:0]                             cmd,
	input  wire logic signed [fsc_pkg::COORD_BITS-1:0]  center_x,
	input  wire logic signed [fsc_pkg::COORD_BITS-1:0]  center_y,
	input  wire logic signed [fsc_pkg::COORD_BITS-1:0]  center_z,
	input  wire logic [fsc_pkg::RAD_BITS-1:0]           sphere_radius,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic                                        outside,
	output logic signed [fsc_pkg::COORD_BITS-1:0]       min_distance,
	output logic                                        behind,
	output logic [fsc_pkg::PIX_BITS-1:0]                pixel_size,
	output logic signed [fsc_pkg::COORD_BITS-1:0]       near_depth,
	output logic signed [fsc_pkg::COORD_BITS-1:0]       far_depth,
	input  wire logic                                   cfg_we,
	input  wire logic [fsc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [fsc_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

	fsc_pkg::cfg_t     cfg;
	fsc_pkg::dp_ctrl_t ctrl;

	fsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	fsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	fsc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.cfg           (cfg),
		.cmd           (cmd),
		.center_x      (center_x),
		.center_y      (center_y),
		.center_z      (center_z),
		.sphere_radius (sphere_radius),
		.outside       (outside),
		.min_distance  (min_distance),
		.behind        (behind),
		.pixel_size    (pixel_size),
		.near_depth    (near_depth),
		.far_depth     (far_depth)
	);

endmodule

`default_nettype wire

// ----- sv/fsc_cfg.sv -----
`default_nettype none

module fsc_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [fsc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [fsc_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
	output fsc_pkg::cfg_t                             cfg
);

	fsc_pkg::cfg_t cfg_q;

	// Write one register per enabled cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plane        <= '0;
			cfg_q.eye_pos      <= '0;
			cfg_q.eye_dir      <= fsc_pkg::EYE_DIR_RESET;
			cfg_q.depth_scale  <= fsc_pkg::DEPTH_SCALE_RESET;
			cfg_q.pixel_factor <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fsc_pkg::REG_PLANE_TOP:    cfg_q.plane[0] <= cfg_wdata;
				fsc_pkg::REG_PLANE_RIGHT:  cfg_q.plane[1] <= cfg_wdata;
				fsc_pkg::REG_PLANE_BOTTOM: cfg_q.plane[2] <= cfg_wdata;
				fsc_pkg::REG_PLANE_LEFT:   cfg_q.plane[3] <= cfg_wdata;
				fsc_pkg::REG_EYE_POS:      cfg_q.eye_pos <= cfg_wdata[fsc_pkg::VEC_BITS-1:0];
				fsc_pkg::REG_EYE_DIR:      cfg_q.eye_dir <= cfg_wdata[fsc_pkg::VEC_BITS-1:0];
				fsc_pkg::REG_DEPTH_SCALE: begin
					cfg_q.depth_scale <= cfg_wdata[fsc_pkg::SCALE_BITS-1:0];
				end
				fsc_pkg::REG_PIXEL_FACTOR: begin
					cfg_q.pixel_factor <= cfg_wdata[fsc_pkg::PF_BITS-1:0];
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- sv/fsc_ctrl.sv -----
`default_nettype none

module fsc_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	output fsc_pkg::dp_ctrl_t ctrl
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]                    state_q;
	logic [fsc_pkg::STEP_BITS-1:0] step_q;
	logic                          out_valid_q;
	logic                          accept;
	logic                          slot_free;
	logic                          at_fin;
	logic                          fin;

	// Take a request only when idle; finish once the result register is free
	always_comb begin
		accept    = in_valid && (state_q == ST_IDLE);
		slot_free = !out_valid_q || !out_stall;
		at_fin    = ((state_q == ST_RUN) && (step_q == fsc_pkg::STEP_FIN)) ||
		            (state_q == ST_HOLD);
		fin       = at_fin && slot_free;
	end

	always_comb begin
		ctrl.load   = accept;
		ctrl.mul_en = (state_q == ST_RUN) && (step_q <= fsc_pkg::STEP_LAST_MUL);
		ctrl.step   = step_q;
		ctrl.fin    = fin;
	end

	// Advance the step sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (step_q == fsc_pkg::STEP_FIN) begin
						state_q <= fin ? ST_IDLE : ST_HOLD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_HOLD: begin
					if (fin) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= fin || (out_valid_q && out_stall);
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- sv/fsc_dp.sv -----
`default_nettype none

module fsc_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire fsc_pkg::dp_ctrl_t                      ctrl,
	input  wire fsc_pkg::cfg_t                          cfg,
	input  wire logic [1:0]                             cmd,
	input  wire logic signed [fsc_pkg::COORD_BITS-1:0]  center_x,
	input  wire logic signed [fsc_pkg::COORD_BITS-1:0]  center_y,
	input  wire logic signed [fsc_pkg::COORD_BITS-1:0]  center_z,
	input  wire logic [fsc_pkg::RAD_BITS-1:0]           sphere_radius,
	output logic                                        outside,
	output logic signed [fsc_pkg::COORD_BITS-1:0]       min_distance,
	output logic                                        behind,
	output logic [fsc_pkg::PIX_BITS-1:0]                pixel_size,
	output logic signed [fsc_pkg::COORD_BITS-1:0]       near_depth,
	output logic signed [fsc_pkg::COORD_BITS-1:0]       far_depth
);

	localparam int CB  = fsc_pkg::COORD_BITS;
	localparam int KB  = fsc_pkg::COEF_BITS;
	localparam int EB  = fsc_pkg::E_BITS;
	localparam int PB  = fsc_pkg::PROD_BITS;
	localparam int SB  = fsc_pkg::SUM_BITS;
	localparam int WB  = fsc_pkg::WIDE_BITS;
	localparam int RB  = fsc_pkg::RS_BITS;
	localparam int DB  = fsc_pkg::DEPTH_BITS;
	localparam int XB  = fsc_pkg::PIX_PROD;
	localparam int NF  = fsc_pkg::NORMAL_FRAC;

	// Request registers
	logic [1:0]                 cmd_q;
	logic signed [CB-1:0]       cx_q, cy_q, cz_q;
	logic [fsc_pkg::RAD_BITS-1:0] r_q;

	// Multiply stage
	logic [fsc_pkg::STEP_BITS-1:0] pidx_full;
	logic [fsc_pkg::PIDX_BITS-1:0] pidx;
	logic [fsc_pkg::CFG_DATA_BITS-1:0] plane_sel;
	logic [fsc_pkg::VEC_BITS-1:0] coef;
	logic signed [KB-1:0]       ca0, ca1, ca2, pd;
	logic signed [KB-1:0]       eye_x, eye_y, eye_z;
	logic signed [EB-1:0]       op0, op1, op2;
	logic signed [CB-1:0]       r_ext;
	logic signed [SB-1:0]       off;
	logic [RB-1:0]              rs;
	logic signed [PB-1:0]       p0_s1, p1_s1, p2_s1;
	logic signed [SB-1:0]       off_s1;
	logic [RB-1:0]              rs_s1;
	logic                       tag_v_s1;
	logic [fsc_pkg::STEP_BITS-1:0] tag_s1;

	// Accumulate stage
	logic signed [SB-1:0]       sum;
	logic signed [WB-1:0]       sum_w, rs_w, depth_w;
	logic signed [SB-1:0]       best_q;
	logic                       behind_s2;
	logic [DB-1:0]              depth_s2;
	logic                       pix_v_s2;
	logic [CB-1:0]              lo_q, hi_q;

	// Pixel stage
	logic [XB-1:0]              pix_prod;
	logic [fsc_pkg::PIX_BITS-1:0] pix_sat;
	logic [fsc_pkg::PIX_BITS-1:0] pix_q;

	// Depth range
	logic signed [CB-1:0]       near_q, far_q, near_nx, far_nx;

	// Capture the request
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= cmd;
			cx_q  <= center_x;
			cy_q  <= center_y;
			cz_q  <= center_z;
			r_q   <= sphere_radius;
		end
	end

	// Select the coefficient vector and operands for this step
	always_comb begin
		pidx_full = ctrl.step - fsc_pkg::STEP_PLANE0;
		pidx      = pidx_full[fsc_pkg::PIDX_BITS-1:0];
		plane_sel = cfg.plane[pidx];
		if (ctrl.step == fsc_pkg::STEP_DIR_C || ctrl.step == fsc_pkg::STEP_DIR_E) begin
			coef = cfg.eye_dir;
		end else begin
			coef = plane_sel[fsc_pkg::VEC_BITS-1:0];
		end
		ca0   = coef[KB-1:0];
		ca1   = coef[2*KB-1:KB];
		ca2   = coef[3*KB-1:2*KB];
		pd    = plane_sel[4*KB-1:3*KB];
		eye_x = cfg.eye_pos[KB-1:0];
		eye_y = cfg.eye_pos[2*KB-1:KB];
		eye_z = cfg.eye_pos[3*KB-1:2*KB];
		if (ctrl.step == fsc_pkg::STEP_DIR_E) begin
			op0 = EB'(cx_q) - EB'(eye_x);
			op1 = EB'(cy_q) - EB'(eye_y);
			op2 = EB'(cz_q) - EB'(eye_z);
		end else begin
			op0 = EB'(cx_q);
			op1 = EB'(cy_q);
			op2 = EB'(cz_q);
		end
		r_ext = {1'b0, r_q};
		if (ctrl.step == fsc_pkg::STEP_DIR_C || ctrl.step == fsc_pkg::STEP_DIR_E) begin
			off = '0;
		end else begin
			off = (SB'(pd) <<< NF) + (SB'(r_ext) <<< NF);
		end
		rs = RB'({r_q, 2'b00}) * RB'(cfg.depth_scale);
	end

	// Register the three products of the shared dot-product unit
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			p0_s1  <= PB'(ca0) * PB'(op0);
			p1_s1  <= PB'(ca1) * PB'(op1);
			p2_s1  <= PB'(ca2) * PB'(op2);
			off_s1 <= off;
			tag_s1 <= ctrl.step;
			if (ctrl.step == fsc_pkg::STEP_DIR_C) begin
				rs_s1 <= rs;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_v_s1 <= 1'b0;
			pix_v_s2 <= 1'b0;
		end else begin
			tag_v_s1 <= ctrl.mul_en;
			pix_v_s2 <= tag_v_s1 && (tag_s1 == fsc_pkg::STEP_DIR_C);
		end
	end

	// Sum the products and sort the result by step
	always_comb begin
		sum     = SB'(p0_s1) + SB'(p1_s1) + SB'(p2_s1) + off_s1;
		sum_w   = WB'(sum);
		rs_w    = WB'({1'b0, rs_s1});
		depth_w = sum_w - rs_w;
	end

	always_ff @(posedge clk) begin
		if (tag_v_s1) begin
			if (tag_s1 == fsc_pkg::STEP_DIR_C) begin
				behind_s2 <= depth_w[WB-1] || (depth_w == '0);
				depth_s2  <= depth_w[DB-1:0];
			end else if (tag_s1 == fsc_pkg::STEP_DIR_E) begin
				lo_q <= fsc_pkg::to_coord(sum_w - rs_w);
				hi_q <= fsc_pkg::to_coord(sum_w + rs_w);
			end else if (tag_s1 == fsc_pkg::STEP_PLANE0 || sum < best_q) begin
				best_q <= sum;
			end
		end
	end

	// Scale the depth to a pixel size and saturate
	always_comb begin
		pix_prod = XB'(depth_s2) * XB'(cfg.pixel_factor);
		if (|pix_prod[XB-1:fsc_pkg::PIX_SHIFT+fsc_pkg::PIX_BITS]) begin
			pix_sat = '1;
		end else begin
			pix_sat = pix_prod[fsc_pkg::PIX_SHIFT+fsc_pkg::PIX_BITS-1:fsc_pkg::PIX_SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (pix_v_s2) begin
			pix_q <= behind_s2 ? '0 : pix_sat;
		end
	end

	// Fold or clear the running depth range
	always_comb begin
		near_nx = near_q;
		far_nx  = far_q;
		unique case (cmd_q)
			fsc_pkg::CMD_FOLD: begin
				if (near_q > $signed(lo_q)) begin
					near_nx = lo_q;
				end
				if (far_q < $signed(hi_q)) begin
					far_nx = hi_q;
				end
			end
			fsc_pkg::CMD_CLEAR: begin
				near_nx = fsc_pkg::COORD_MAX;
				far_nx  = fsc_pkg::COORD_MIN;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= fsc_pkg::COORD_MAX;
			far_q  <= fsc_pkg::COORD_MIN;
		end else if (ctrl.fin) begin
			near_q <= near_nx;
			far_q  <= far_nx;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (ctrl.fin) begin
			outside      <= best_q[SB-1];
			min_distance <= fsc_pkg::to_coord(WB'(best_q));
			behind       <= behind_s2;
			pixel_size   <= pix_q;
			near_depth   <= near_nx;
			far_depth    <= far_nx;
		end
	end

endmodule

`default_nettype wire

// ----- sv/fsc_checker.sv -----
`default_nettype none

module fsc_checker (
	input wire logic                                   clk,
	input wire logic                                   arst_n,
	input wire logic                                   in_valid,
	input wire logic                                   in_stall,
	input wire logic                                   out_valid,
	input wire logic                                   out_stall,
	input wire logic [fsc_pkg::PIX_BITS-1:0]           pixel_size,
	input wire logic signed [fsc_pkg::COORD_BITS-1:0]  near_depth,
	input wire logic signed [fsc_pkg::COORD_BITS-1:0]  min_distance
);

	// A request keeps the block busy for at least the dot-product steps
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> ##3 in_stall)
		else $error("request accepted again too soon");

	// A result appears only out of a busy period
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a request in progress");

	// Going idle leaves a finished result in the output register
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("block went idle without a result");

	// Hold a stalled result
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pixel_size) &&
		                              $stable(near_depth) && $stable(min_distance)))
		else $error("stalled result changed");

endmodule

bind frustum_sphere_cull_core fsc_checker u_fsc_checker (.*);

`default_nettype wire
